[hdl/segint_pkg.sv]
// ----------------------------------------------------------------------------
// segint_pkg
// Widths, types and register codes shared by the segment intersection blocks.
// ----------------------------------------------------------------------------
package segint_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int NUM_COORDS  = 8;

   // cross products and their magnitudes
   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;

   // tolerance registers
   localparam int PTOL_W     = 40;
   localparam int ETOL_W     = 16;
   localparam int ETOL_SHIFT = 16;
   localparam int PAR_CMP_W  = (CROSS_W > PTOL_W) ? CROSS_W : PTOL_W;

   // range test on numerators scaled by 2^ETOL_SHIFT
   localparam int SLACK_W = CROSS_W + ETOL_W;
   localparam int LHS_W   = CROSS_W + ETOL_SHIFT + 2;

   // point offset: |tnum| * |delta| split in two partial products
   localparam int SPLIT_W = (CROSS_W + 1) / 2;
   localparam int HI_W    = CROSS_W - SPLIT_W;
   localparam int LO_P_W  = SPLIT_W + COORD_WIDTH;
   localparam int HI_P_W  = HI_W + COORD_WIDTH;
   localparam int MAG_W   = CROSS_W + COORD_WIDTH;

   // divider: quotient below 2^QUO_W whenever the segments hit
   localparam int DVS_W = CROSS_W + 1;
   localparam int DVD_W = MAG_W + 2;
   localparam int QUO_W = COORD_WIDTH + 2;
   localparam int SUM_W = QUO_W + 2;

   // ports
   localparam int CSR_W      = PTOL_W;
   localparam int CSR_ADDR_W = 1;
   localparam int REQ_DATA_W = ((NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * COORD_WIDTH + 1 + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - 2 * COORD_WIDTH - 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [CROSS_W-1:0]     xprod_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PAR_TOL = 1'b0,
      CSR_PRM_TOL = 1'b1
   } csr_addr_type;

   typedef struct packed {
      xprod_type den;
      xprod_type tnum;
      xprod_type unum;
      coord_type base_x;
      coord_type base_y;
      diff_type  delta_x;
      diff_type  delta_y;
   } cross_res_type;

   typedef struct packed {
      logic             hit;
      logic [DVS_W-1:0] dvs;
      logic [DVD_W-1:0] dvd_x;
      logic [DVD_W-1:0] dvd_y;
      coord_type        base_x;
      coord_type        base_y;
      logic             neg_x;
      logic             neg_y;
   } div_req_type;

   typedef struct packed {
      logic             hit;
      logic [QUO_W-1:0] quo_x;
      logic [QUO_W-1:0] quo_y;
      coord_type        base_x;
      coord_type        base_y;
      logic             neg_x;
      logic             neg_y;
   } div_res_type;

endpackage

[hdl/segint_cross.sv]
// ----------------------------------------------------------------------------
// segint_cross
// Three stages: edge vectors, six products, denominator and both numerators.
// ----------------------------------------------------------------------------
module segint_cross
   import segint_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_vld,
   input  logic [REQ_DATA_W-1:0] in_data,
   output logic                  out_vld,
   output cross_res_type         out_res
);

   typedef struct packed {
      coord_type px;
      coord_type py;
      diff_type  pqx;
      diff_type  pqy;
      diff_type  rsx;
      diff_type  rsy;
      diff_type  prx;
      diff_type  pry;
   } s1_type;

   typedef struct packed {
      coord_type px;
      coord_type py;
      diff_type  pqx;
      diff_type  pqy;
      prod_type  p_den0;
      prod_type  p_den1;
      prod_type  p_t0;
      prod_type  p_t1;
      prod_type  p_u0;
      prod_type  p_u1;
   } s2_type;

   coord_type     px, py, qx, qy, rx, ry, sx, sy;
   s1_type        s1_in, s1_ff;
   s2_type        s2_in, s2_ff;
   cross_res_type s3_in, s3_ff;
   logic          vld1_ff, vld2_ff, vld3_ff;

   assign px = in_data[0*COORD_WIDTH +: COORD_WIDTH];
   assign py = in_data[1*COORD_WIDTH +: COORD_WIDTH];
   assign qx = in_data[2*COORD_WIDTH +: COORD_WIDTH];
   assign qy = in_data[3*COORD_WIDTH +: COORD_WIDTH];
   assign rx = in_data[4*COORD_WIDTH +: COORD_WIDTH];
   assign ry = in_data[5*COORD_WIDTH +: COORD_WIDTH];
   assign sx = in_data[6*COORD_WIDTH +: COORD_WIDTH];
   assign sy = in_data[7*COORD_WIDTH +: COORD_WIDTH];

   always_comb begin
      s1_in.px  = px;
      s1_in.py  = py;
      s1_in.pqx = $signed(qx) - $signed(px);
      s1_in.pqy = $signed(qy) - $signed(py);
      s1_in.rsx = $signed(sx) - $signed(rx);
      s1_in.rsy = $signed(sy) - $signed(ry);
      s1_in.prx = $signed(rx) - $signed(px);
      s1_in.pry = $signed(ry) - $signed(py);
   end

   always_comb begin
      s2_in.px     = s1_ff.px;
      s2_in.py     = s1_ff.py;
      s2_in.pqx    = s1_ff.pqx;
      s2_in.pqy    = s1_ff.pqy;
      s2_in.p_den0 = $signed(s1_ff.pqx) * $signed(s1_ff.rsy);
      s2_in.p_den1 = $signed(s1_ff.pqy) * $signed(s1_ff.rsx);
      s2_in.p_t0   = $signed(s1_ff.prx) * $signed(s1_ff.rsy);
      s2_in.p_t1   = $signed(s1_ff.pry) * $signed(s1_ff.rsx);
      s2_in.p_u0   = $signed(s1_ff.prx) * $signed(s1_ff.pqy);
      s2_in.p_u1   = $signed(s1_ff.pry) * $signed(s1_ff.pqx);
   end

   always_comb begin
      s3_in.den     = $signed(s2_ff.p_den0) - $signed(s2_ff.p_den1);
      s3_in.tnum    = $signed(s2_ff.p_t0) - $signed(s2_ff.p_t1);
      s3_in.unum    = $signed(s2_ff.p_u0) - $signed(s2_ff.p_u1);
      s3_in.base_x  = s2_ff.px;
      s3_in.base_y  = s2_ff.py;
      s3_in.delta_x = s2_ff.pqx;
      s3_in.delta_y = s2_ff.pqy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign out_vld = vld3_ff;
   assign out_res = s3_ff;

endmodule

[hdl/segint_test.sv]
// ----------------------------------------------------------------------------
// segint_test
// Sign normalization, parallel and range tests, offset products, and the
// dividend/divisor for the rounded point offset. Five stages.
// ----------------------------------------------------------------------------
module segint_test
   import segint_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [PTOL_W-1:0] par_tol,
   input  logic [ETOL_W-1:0] prm_tol,
   input  logic              in_vld,
   input  cross_res_type     in_res,
   output logic              out_vld,
   output div_req_type       out_req
);

   typedef struct packed {
      logic [CROSS_W-1:0]     den;
      xprod_type              tn;
      xprod_type              un;
      logic                   par;
      coord_type              base_x;
      coord_type              base_y;
      logic [COORD_WIDTH-1:0] dxm;
      logic [COORD_WIDTH-1:0] dym;
      logic                   dxs;
      logic                   dys;
   } s4_type;

   typedef struct packed {
      logic [CROSS_W-1:0]     den;
      xprod_type              tn;
      xprod_type              un;
      logic [CROSS_W-1:0]     tmag;
      logic [SLACK_W-1:0]     slack;
      logic                   par;
      coord_type              base_x;
      coord_type              base_y;
      logic [COORD_WIDTH-1:0] dxm;
      logic [COORD_WIDTH-1:0] dym;
      logic                   neg_x;
      logic                   neg_y;
   } s5_type;

   typedef struct packed {
      logic [CROSS_W-1:0] den;
      xprod_type          tn;
      xprod_type          un;
      logic [LHS_W-1:0]   upper;
      logic               lo_ok_t;
      logic               lo_ok_u;
      logic               par;
      logic [LO_P_W-1:0]  px_lo;
      logic [HI_P_W-1:0]  px_hi;
      logic [LO_P_W-1:0]  py_lo;
      logic [HI_P_W-1:0]  py_hi;
      coord_type          base_x;
      coord_type          base_y;
      logic               neg_x;
      logic               neg_y;
   } s6_type;

   typedef struct packed {
      logic               hit;
      logic [CROSS_W-1:0] den;
      logic [MAG_W-1:0]   mag_x;
      logic [MAG_W-1:0]   mag_y;
      coord_type          base_x;
      coord_type          base_y;
      logic               neg_x;
      logic               neg_y;
   } s7_type;

   s4_type      s4_in, s4_ff;
   s5_type      s5_in, s5_ff;
   s6_type      s6_in, s6_ff;
   s7_type      s7_in, s7_ff;
   div_req_type s8_in, s8_ff;
   logic        vld4_ff, vld5_ff, vld6_ff, vld7_ff, vld8_ff;

   logic                      den_neg;
   logic [DIFF_W-1:0]         dx_abs, dy_abs;
   logic signed [LHS_W-1:0]   slack_ext;
   logic signed [LHS_W-1:0]   lhs6_t, lhs6_u, lo_sum_t, lo_sum_u;
   logic signed [LHS_W-1:0]   lhs7_t, lhs7_u, upper7;
   logic                      hi_ok_t, hi_ok_u;

   // stage 4: make the denominator positive, parallel test on |den|
   always_comb begin
      den_neg      = in_res.den[CROSS_W-1];
      s4_in.den    = den_neg ? -in_res.den : in_res.den;
      s4_in.tn     = den_neg ? -in_res.tnum : in_res.tnum;
      s4_in.un     = den_neg ? -in_res.unum : in_res.unum;
      s4_in.par    = PAR_CMP_W'(s4_in.den) <= PAR_CMP_W'(par_tol);
      dx_abs       = in_res.delta_x[DIFF_W-1] ? -in_res.delta_x : in_res.delta_x;
      dy_abs       = in_res.delta_y[DIFF_W-1] ? -in_res.delta_y : in_res.delta_y;
      s4_in.dxm    = dx_abs[COORD_WIDTH-1:0];
      s4_in.dym    = dy_abs[COORD_WIDTH-1:0];
      s4_in.dxs    = in_res.delta_x[DIFF_W-1];
      s4_in.dys    = in_res.delta_y[DIFF_W-1];
      s4_in.base_x = in_res.base_x;
      s4_in.base_y = in_res.base_y;
   end

   // stage 5: slack = den * e, |tnum| and offset signs
   always_comb begin
      s5_in.den    = s4_ff.den;
      s5_in.tn     = s4_ff.tn;
      s5_in.un     = s4_ff.un;
      s5_in.tmag   = s4_ff.tn[CROSS_W-1] ? -s4_ff.tn : s4_ff.tn;
      s5_in.slack  = s4_ff.den * prm_tol;
      s5_in.par    = s4_ff.par;
      s5_in.base_x = s4_ff.base_x;
      s5_in.base_y = s4_ff.base_y;
      s5_in.dxm    = s4_ff.dxm;
      s5_in.dym    = s4_ff.dym;
      s5_in.neg_x  = s4_ff.tn[CROSS_W-1] ^ s4_ff.dxs;
      s5_in.neg_y  = s4_ff.tn[CROSS_W-1] ^ s4_ff.dys;
   end

   // stage 6: lower bounds (num*2^16 >= -slack), upper bound sum, partial products
   always_comb begin
      slack_ext = {{(LHS_W-SLACK_W){1'b0}}, s5_ff.slack};
      lhs6_t    = {{(LHS_W-CROSS_W-ETOL_SHIFT){s5_ff.tn[CROSS_W-1]}}, s5_ff.tn,
                   {ETOL_SHIFT{1'b0}}};
      lhs6_u    = {{(LHS_W-CROSS_W-ETOL_SHIFT){s5_ff.un[CROSS_W-1]}}, s5_ff.un,
                   {ETOL_SHIFT{1'b0}}};
      lo_sum_t  = lhs6_t + slack_ext;
      lo_sum_u  = lhs6_u + slack_ext;

      s6_in.den     = s5_ff.den;
      s6_in.tn      = s5_ff.tn;
      s6_in.un      = s5_ff.un;
      s6_in.upper   = {{(LHS_W-CROSS_W-ETOL_SHIFT){1'b0}}, s5_ff.den, {ETOL_SHIFT{1'b0}}}
                      + slack_ext;
      s6_in.lo_ok_t = !lo_sum_t[LHS_W-1];
      s6_in.lo_ok_u = !lo_sum_u[LHS_W-1];
      s6_in.par     = s5_ff.par;
      s6_in.px_lo   = s5_ff.tmag[SPLIT_W-1:0] * s5_ff.dxm;
      s6_in.px_hi   = s5_ff.tmag[CROSS_W-1:SPLIT_W] * s5_ff.dxm;
      s6_in.py_lo   = s5_ff.tmag[SPLIT_W-1:0] * s5_ff.dym;
      s6_in.py_hi   = s5_ff.tmag[CROSS_W-1:SPLIT_W] * s5_ff.dym;
      s6_in.base_x  = s5_ff.base_x;
      s6_in.base_y  = s5_ff.base_y;
      s6_in.neg_x   = s5_ff.neg_x;
      s6_in.neg_y   = s5_ff.neg_y;
   end

   // stage 7: upper bounds, hit decision, offset magnitudes
   always_comb begin
      lhs7_t  = {{(LHS_W-CROSS_W-ETOL_SHIFT){s6_ff.tn[CROSS_W-1]}}, s6_ff.tn,
                 {ETOL_SHIFT{1'b0}}};
      lhs7_u  = {{(LHS_W-CROSS_W-ETOL_SHIFT){s6_ff.un[CROSS_W-1]}}, s6_ff.un,
                 {ETOL_SHIFT{1'b0}}};
      upper7  = s6_ff.upper;
      hi_ok_t = lhs7_t <= upper7;
      hi_ok_u = lhs7_u <= upper7;

      s7_in.hit    = !s6_ff.par && s6_ff.lo_ok_t && s6_ff.lo_ok_u && hi_ok_t && hi_ok_u;
      s7_in.den    = s6_ff.den;
      s7_in.mag_x  = {{(MAG_W-LO_P_W){1'b0}}, s6_ff.px_lo} + {s6_ff.px_hi, {SPLIT_W{1'b0}}};
      s7_in.mag_y  = {{(MAG_W-LO_P_W){1'b0}}, s6_ff.py_lo} + {s6_ff.py_hi, {SPLIT_W{1'b0}}};
      s7_in.base_x = s6_ff.base_x;
      s7_in.base_y = s6_ff.base_y;
      s7_in.neg_x  = s6_ff.neg_x;
      s7_in.neg_y  = s6_ff.neg_y;
   end

   // stage 8: round to nearest as (2*mag + den) / (2*den)
   always_comb begin
      s8_in.hit    = s7_ff.hit;
      s8_in.dvs    = {s7_ff.den, 1'b0};
      s8_in.dvd_x  = {1'b0, s7_ff.mag_x, 1'b0} + {{(DVD_W-CROSS_W){1'b0}}, s7_ff.den};
      s8_in.dvd_y  = {1'b0, s7_ff.mag_y, 1'b0} + {{(DVD_W-CROSS_W){1'b0}}, s7_ff.den};
      s8_in.base_x = s7_ff.base_x;
      s8_in.base_y = s7_ff.base_y;
      s8_in.neg_x  = s7_ff.neg_x;
      s8_in.neg_y  = s7_ff.neg_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
         vld8_ff <= 1'b0;
      end else if (en) begin
         vld4_ff <= in_vld;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
         vld7_ff <= vld6_ff;
         vld8_ff <= vld7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         s8_ff <= s8_in;
      end
   end

   assign out_vld = vld8_ff;
   assign out_req = s8_ff;

endmodule

[hdl/segint_div.sv]
// ----------------------------------------------------------------------------
// segint_div
// Pipelined restoring divider, one quotient bit per stage, x and y lanes
// sharing one divisor.
// ----------------------------------------------------------------------------
module segint_div
   import segint_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_vld,
   input  div_req_type in_req,
   output logic        out_vld,
   output div_res_type out_res
);

   typedef struct packed {
      logic             hit;
      logic [DVS_W-1:0] dvs;
      logic [DVS_W-1:0] rem_x;
      logic [DVS_W-1:0] rem_y;
      logic [QUO_W-1:0] low_x;
      logic [QUO_W-1:0] low_y;
      logic [QUO_W-1:0] quo_x;
      logic [QUO_W-1:0] quo_y;
      coord_type        base_x;
      coord_type        base_y;
      logic             neg_x;
      logic             neg_y;
   } stage_type;

   stage_type        head;
   stage_type        stg_in [QUO_W];
   stage_type        stg_ff [QUO_W];
   logic [QUO_W-1:0] vld_in, vld_ff;

   function automatic stage_type div_step(input stage_type s);
      stage_type      r;
      logic [DVS_W:0] sh_x;
      logic [DVS_W:0] sh_y;
      logic [DVS_W:0] dif_x;
      logic [DVS_W:0] dif_y;
      r       = s;
      sh_x    = {s.rem_x, s.low_x[QUO_W-1]};
      sh_y    = {s.rem_y, s.low_y[QUO_W-1]};
      dif_x   = sh_x - {1'b0, s.dvs};
      dif_y   = sh_y - {1'b0, s.dvs};
      r.low_x = {s.low_x[QUO_W-2:0], 1'b0};
      r.low_y = {s.low_y[QUO_W-2:0], 1'b0};
      if (sh_x >= {1'b0, s.dvs}) begin
         r.rem_x = dif_x[DVS_W-1:0];
         r.quo_x = {s.quo_x[QUO_W-2:0], 1'b1};
      end else begin
         r.rem_x = sh_x[DVS_W-1:0];
         r.quo_x = {s.quo_x[QUO_W-2:0], 1'b0};
      end
      if (sh_y >= {1'b0, s.dvs}) begin
         r.rem_y = dif_y[DVS_W-1:0];
         r.quo_y = {s.quo_y[QUO_W-2:0], 1'b1};
      end else begin
         r.rem_y = sh_y[DVS_W-1:0];
         r.quo_y = {s.quo_y[QUO_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // the top dividend bits start as the partial remainder
   always_comb begin
      head.hit    = in_req.hit;
      head.dvs    = in_req.dvs;
      head.rem_x  = DVS_W'(in_req.dvd_x[DVD_W-1:QUO_W]);
      head.rem_y  = DVS_W'(in_req.dvd_y[DVD_W-1:QUO_W]);
      head.low_x  = in_req.dvd_x[QUO_W-1:0];
      head.low_y  = in_req.dvd_y[QUO_W-1:0];
      head.quo_x  = '0;
      head.quo_y  = '0;
      head.base_x = in_req.base_x;
      head.base_y = in_req.base_y;
      head.neg_x  = in_req.neg_x;
      head.neg_y  = in_req.neg_y;
   end

   always_comb begin
      stg_in[0] = div_step(head);
      for (int k = 1; k < QUO_W; k++) begin
         stg_in[k] = div_step(stg_ff[k-1]);
      end
   end

   assign vld_in = {vld_ff[QUO_W-2:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QUO_W; k++) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign out_vld        = vld_ff[QUO_W-1];
   assign out_res.hit    = stg_ff[QUO_W-1].hit;
   assign out_res.quo_x  = stg_ff[QUO_W-1].quo_x;
   assign out_res.quo_y  = stg_ff[QUO_W-1].quo_y;
   assign out_res.base_x = stg_ff[QUO_W-1].base_x;
   assign out_res.base_y = stg_ff[QUO_W-1].base_y;
   assign out_res.neg_x  = stg_ff[QUO_W-1].neg_x;
   assign out_res.neg_y  = stg_ff[QUO_W-1].neg_y;

endmodule

[hdl/segment_intersection.sv]
// ----------------------------------------------------------------------------
// segment_intersection
// Fixed-point crossing test of two 2D segments with rounded, saturated point.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  req_tdata: p, q, r, s (x then y)
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: hit, cross_x, cross_y
//   csr      in   csr_we                 csr_addr, csr_wdata
//
// One word per clock in and out while rsp_tready is high and the skid
// register is empty. The divider chain resolves one quotient bit per stage.
// Synchronous reset clears valid bits and both tolerances. The whole
// pipeline holds together while the skid register is full; past the output
// register, the skid takes one more result after rsp stalls before input halts.
// ----------------------------------------------------------------------------
module segment_intersection
   import segint_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // p.x, p.y, q.x, q.y, r.x, r.y, s.x, s.y
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit, cross_x, cross_y, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata
);

   typedef struct packed {
      logic      hit;
      coord_type cross_x;
      coord_type cross_y;
   } rsp_type;

   localparam logic signed [SUM_W-1:0] SUM_MAX =
      {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN =
      {{(SUM_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   logic [PTOL_W-1:0] par_tol_ff;
   logic [ETOL_W-1:0] prm_tol_ff;

   logic          en;
   logic          crs_vld, tst_vld, div_vld;
   cross_res_type crs_res;
   div_req_type   tst_req;
   div_res_type   div_res;

   rsp_type res;
   rsp_type out_in, out_ff, skd_in, skd_ff;
   logic    rsp_vld_in, rsp_vld_ff, skd_vld_in, skd_vld_ff;

   function automatic coord_type place(input coord_type base, input logic [QUO_W-1:0] off,
                                       input logic neg);
      logic signed [SUM_W-1:0] b;
      logic signed [SUM_W-1:0] o;
      logic signed [SUM_W-1:0] sum;
      b   = {{(SUM_W-COORD_WIDTH){base[COORD_WIDTH-1]}}, base};
      o   = {{(SUM_W-QUO_W){1'b0}}, off};
      sum = neg ? b - o : b + o;
      if (sum > SUM_MAX) begin
         sum = SUM_MAX;
      end else if (sum < SUM_MIN) begin
         sum = SUM_MIN;
      end
      return sum[COORD_WIDTH-1:0];
   endfunction

   // tolerance registers
   always_ff @(posedge clock) begin
      if (reset) begin
         par_tol_ff <= '0;
         prm_tol_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr_type'(csr_addr))
            CSR_PAR_TOL: par_tol_ff <= csr_wdata[PTOL_W-1:0];
            CSR_PRM_TOL: prm_tol_ff <= csr_wdata[ETOL_W-1:0];
            default: ;
         endcase
      end
   end

   assign en         = !skd_vld_ff;
   assign req_tready = en;

   segint_cross u_cross (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_tvalid),
      .in_data (req_tdata),
      .out_vld (crs_vld),
      .out_res (crs_res)
   );

   segint_test u_test (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .par_tol (par_tol_ff),
      .prm_tol (prm_tol_ff),
      .in_vld  (crs_vld),
      .in_res  (crs_res),
      .out_vld (tst_vld),
      .out_req (tst_req)
   );

   segint_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (tst_vld),
      .in_req  (tst_req),
      .out_vld (div_vld),
      .out_res (div_res)
   );

   // final add and clamp; a miss reports the origin
   always_comb begin
      res.hit     = div_res.hit;
      res.cross_x = div_res.hit ? place(div_res.base_x, div_res.quo_x, div_res.neg_x) : '0;
      res.cross_y = div_res.hit ? place(div_res.base_y, div_res.quo_y, div_res.neg_y) : '0;
   end

   // output register with skid
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      skd_vld_in = skd_vld_ff;
      out_in     = out_ff;
      skd_in     = skd_ff;
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      if (skd_vld_ff) begin
         if (rsp_tready) begin
            rsp_vld_in = 1'b1;
            out_in     = skd_ff;
            skd_vld_in = 1'b0;
         end
      end else if (div_vld) begin
         if (!rsp_vld_ff || rsp_tready) begin
            rsp_vld_in = 1'b1;
            out_in     = res;
         end else begin
            skd_vld_in = 1'b1;
            skd_in     = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         skd_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         skd_vld_ff <= skd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skd_ff <= skd_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_ff.cross_y, out_ff.cross_x, out_ff.hit};

endmodule
